// ===== rtl/core/segment_plane_intersection_macros.svh =====
// Assertion macros shared by the segment/plane intersection RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SEGMENT_PLANE_INTERSECTION_MACROS_SVH
`define SEGMENT_PLANE_INTERSECTION_MACROS_SVH

// Same-cycle implication under reset
`define SPI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication after a fixed number of cycles
`define SPI_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/spi_pkg.sv =====
// Shared constants, types and saturating helpers for the segment/plane block.
// Depends on nothing.
package spi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int XW = 32;
	localparam int WW = 64;

	// Beat data that rides alongside the divider
	typedef struct packed {
		logic                 miss;
		logic signed [XW-1:0] p1x;
		logic signed [XW-1:0] p1y;
		logic signed [XW-1:0] p1z;
		logic signed [XW-1:0] rx;
		logic signed [XW-1:0] ry;
		logic signed [XW-1:0] rz;
	} side_t;

	localparam logic signed [WW-1:0] S64_MAX = {1'b0, {(WW-1){1'b1}}};
	localparam logic signed [WW-1:0] S64_MIN = {1'b1, {(WW-1){1'b0}}};

	function automatic logic signed [WW-1:0] sat_add64(input logic signed [WW-1:0] a,
			input logic signed [WW-1:0] b);
		logic signed [WW:0] s;
		s = {a[WW-1], a} + {b[WW-1], b};
		if (s[WW] != s[WW-1])
			return s[WW] ? S64_MIN : S64_MAX;
		return s[WW-1:0];
	endfunction

	function automatic logic signed [WW-1:0] sat_neg64(input logic signed [WW-1:0] a);
		if (a == S64_MIN)
			return S64_MAX;
		return -a;
	endfunction

	function automatic logic [WW-1:0] mag64(input logic signed [WW-1:0] a);
		return a[WW-1] ? (~a + 1'b1) : a;
	endfunction

endpackage

// ===== rtl/core/segment_plane_intersection.sv =====
// Segment/plane intersection, fully pipelined from accept to the done strobe:
// one beat accepted every cycle, busy stays low.
// Five front stages (ray, products, dot sums, numerator, range check), one divider
// stage per quotient bit (FRAC_BITS+1), then a scale multiply and an output stage.
// The receiver cannot stall, so no beat ever waits inside the pipeline.
// Asynchronous active-low reset clears all valid bits; in-flight beats drop.
module segment_plane_intersection #(
	parameter int FRAC_BITS = spi_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [spi_pkg::XW-1:0]   normal_x,
	input  logic signed [spi_pkg::XW-1:0]   normal_y,
	input  logic signed [spi_pkg::XW-1:0]   normal_z,
	input  logic signed [spi_pkg::XW-1:0]   plane_offset,
	input  logic signed [spi_pkg::XW-1:0]   start_x,
	input  logic signed [spi_pkg::XW-1:0]   start_y,
	input  logic signed [spi_pkg::XW-1:0]   start_z,
	input  logic signed [spi_pkg::XW-1:0]   end_x,
	input  logic signed [spi_pkg::XW-1:0]   end_y,
	input  logic signed [spi_pkg::XW-1:0]   end_z,
	output logic                            done,
	output logic                            hit,
	output logic signed [spi_pkg::XW-1:0]   cross_x,
	output logic signed [spi_pkg::XW-1:0]   cross_y,
	output logic signed [spi_pkg::XW-1:0]   cross_z
);
	`include "segment_plane_intersection_macros.svh"

	localparam int XW = spi_pkg::XW;
	localparam int WW = spi_pkg::WW;
	localparam int LAT = FRAC_BITS + 8;
	localparam int PW = XW + FRAC_BITS + 2;
	localparam logic signed [XW-1:0] S32_MAX = {1'b0, {(XW-1){1'b1}}};
	localparam logic signed [XW-1:0] S32_MIN = {1'b1, {(XW-1){1'b0}}};

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// ---- stage 1: ray r = p2 - p1, saturated
	logic signed [XW:0]   diff [3];
	logic signed [XW-1:0] inp_p1 [3];
	logic signed [XW-1:0] inp_p2 [3];
	logic                 vld_s1;
	logic signed [XW-1:0] n_s1 [3];
	logic signed [XW-1:0] p1_s1 [3];
	logic signed [XW-1:0] r_s1 [3];
	logic signed [XW-1:0] d_s1;

	always_comb begin
		inp_p1[0] = start_x; inp_p1[1] = start_y; inp_p1[2] = start_z;
		inp_p2[0] = end_x;   inp_p2[1] = end_y;   inp_p2[2] = end_z;
		for (int i = 0; i < 3; i++)
			diff[i] = {inp_p2[i][XW-1], inp_p2[i]} - {inp_p1[i][XW-1], inp_p1[i]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		n_s1[0] <= normal_x; n_s1[1] <= normal_y; n_s1[2] <= normal_z;
		d_s1    <= plane_offset;
		for (int i = 0; i < 3; i++) begin
			p1_s1[i] <= inp_p1[i];
			if (diff[i][XW] != diff[i][XW-1])
				r_s1[i] <= diff[i][XW] ? S32_MIN : S32_MAX;
			else
				r_s1[i] <= diff[i][XW-1:0];
		end
	end

	// ---- stage 2: the six products n.p1 and n.r
	logic                 vld_s2;
	logic signed [WW-1:0] np_s2 [3];
	logic signed [WW-1:0] nr_s2 [3];
	logic signed [XW-1:0] p1_s2 [3];
	logic signed [XW-1:0] r_s2 [3];
	logic signed [XW-1:0] d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			np_s2[i] <= WW'(n_s1[i]) * WW'(p1_s1[i]);
			nr_s2[i] <= WW'(n_s1[i]) * WW'(r_s1[i]);
			p1_s2[i] <= p1_s1[i];
			r_s2[i]  <= r_s1[i];
		end
		d_s2 <= d_s1;
	end

	// ---- stage 3: saturating dot sums and the scaled plane term
	logic signed [WW-1:0] nd;
	logic                 vld_s3;
	logic signed [WW-1:0] dp_s3, dr_s3, nd_s3;
	logic signed [XW-1:0] p1_s3 [3];
	logic signed [XW-1:0] r_s3 [3];

	always_comb begin
		nd = -({{(WW-XW){d_s2[XW-1]}}, d_s2} <<< FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		dp_s3 <= spi_pkg::sat_add64(spi_pkg::sat_add64(np_s2[0], np_s2[1]), np_s2[2]);
		dr_s3 <= spi_pkg::sat_add64(spi_pkg::sat_add64(nr_s2[0], nr_s2[1]), nr_s2[2]);
		nd_s3 <= nd;
		p1_s3 <= p1_s2;
		r_s3  <= r_s2;
	end

	// ---- stage 4: numerator and denominator
	logic                 vld_s4;
	logic signed [WW-1:0] num_s4, den_s4;
	logic signed [XW-1:0] p1_s4 [3];
	logic signed [XW-1:0] r_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		num_s4 <= spi_pkg::sat_add64(nd_s3, spi_pkg::sat_neg64(dp_s3));
		den_s4 <= dr_s3;
		p1_s4  <= p1_s3;
		r_s4   <= r_s3;
	end

	// ---- stage 5: sign and range check, magnitudes for the divider
	logic [WW-1:0]  un, ud;
	logic           miss;
	logic           vld_s5;
	logic [WW-1:0]  un_s5, ud_s5;
	spi_pkg::side_t side_s5;

	always_comb begin
		un   = spi_pkg::mag64(num_s4);
		ud   = spi_pkg::mag64(den_s4);
		miss = (den_s4 == '0)
			|| ((num_s4 != '0) && (num_s4[WW-1] != den_s4[WW-1]))
			|| (un > ud);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		un_s5        <= un;
		ud_s5        <= ud;
		side_s5.miss <= miss;
		side_s5.p1x  <= p1_s4[0];
		side_s5.p1y  <= p1_s4[1];
		side_s5.p1z  <= p1_s4[2];
		side_s5.rx   <= r_s4[0];
		side_s5.ry   <= r_s4[1];
		side_s5.rz   <= r_s4[2];
	end

	// ---- divider: t = un/ud with FRAC_BITS fraction bits
	logic               vld_dv;
	logic [FRAC_BITS:0] t_dv;
	spi_pkg::side_t     side_dv;

	spi_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s5),
		.num      (un_s5),
		.den      (ud_s5),
		.side_in  (side_s5),
		.out_valid(vld_dv),
		.quot     (t_dv),
		.side_out (side_dv)
	);

	// ---- scale stage: r_i * t, exact
	logic signed [XW-1:0]    rd [3];
	logic signed [FRAC_BITS+1:0] ts;
	logic                    vld_sm;
	logic                    miss_sm;
	logic signed [PW-1:0]    prod_sm [3];
	logic signed [XW-1:0]    p1_sm [3];

	always_comb begin
		rd[0] = side_dv.rx; rd[1] = side_dv.ry; rd[2] = side_dv.rz;
		ts    = {1'b0, t_dv};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sm <= 1'b0;
		end else begin
			vld_sm <= vld_dv;
		end
	end

	always_ff @(posedge clk) begin
		miss_sm  <= side_dv.miss;
		p1_sm[0] <= side_dv.p1x;
		p1_sm[1] <= side_dv.p1y;
		p1_sm[2] <= side_dv.p1z;
		for (int i = 0; i < 3; i++)
			prod_sm[i] <= PW'(rd[i]) * PW'(ts);
	end

	// ---- output stage: floor shift, add p1, saturate; zero on miss
	logic signed [PW-1:0] shf [3];
	logic signed [XW+1:0] sum [3];
	logic signed [XW-1:0] pt  [3];
	logic signed [XW-1:0] xyz_q [3];
	logic                 hit_q;
	logic                 done_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			shf[i] = prod_sm[i] >>> FRAC_BITS;
			sum[i] = (XW+2)'(p1_sm[i]) + shf[i][XW+1:0];
			if (sum[i] > (XW+2)'(S32_MAX))
				pt[i] = S32_MAX;
			else if (sum[i] < (XW+2)'(S32_MIN))
				pt[i] = S32_MIN;
			else
				pt[i] = sum[i][XW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_sm;
		end
	end

	always_ff @(posedge clk) begin
		hit_q <= !miss_sm;
		for (int i = 0; i < 3; i++)
			xyz_q[i] <= miss_sm ? '0 : pt[i];
	end

	assign done    = done_q;
	assign hit     = hit_q;
	assign cross_x = xyz_q[0];
	assign cross_y = xyz_q[1];
	assign cross_z = xyz_q[2];

	// ---- checks
	`SPI_ASSERT_DELAY(a_latency, clk, arst_n, accept, LAT, done,
		"accepted beat did not finish after the pipeline latency")
	`SPI_ASSERT_IMPL(a_miss_zero, clk, arst_n, done && !hit,
		(cross_x == '0) && (cross_y == '0) && (cross_z == '0),
		"miss result carries nonzero coordinates")
	`SPI_ASSERT_DELAY(a_no_phantom, clk, arst_n, !accept, LAT, !done,
		"result strobe without an accepted beat")
endmodule

// ===== rtl/core/spi_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, FRAC_BITS+1 stages.
// Depends on spi_pkg for the side-band beat type.
module spi_div #(
	parameter int FRAC_BITS = spi_pkg::FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [spi_pkg::WW-1:0]   num,
	input  logic [spi_pkg::WW-1:0]   den,
	input  spi_pkg::side_t           side_in,
	output logic                     out_valid,
	output logic [FRAC_BITS:0]       quot,
	output spi_pkg::side_t           side_out
);
	localparam int NST = FRAC_BITS + 1;
	localparam int RW = spi_pkg::WW + 1;

	logic                   vld_q  [NST+1];
	logic [RW-1:0]          rem_q  [NST+1];
	logic [FRAC_BITS:0]     quo_q  [NST+1];
	logic [spi_pkg::WW-1:0] den_q  [NST+1];
	spi_pkg::side_t         side_q [NST+1];

	// stage zero is the incoming beat
	always_comb begin
		vld_q[0]  = in_valid;
		rem_q[0]  = {1'b0, num};
		quo_q[0]  = '0;
		den_q[0]  = den;
		side_q[0] = side_in;
	end

	for (genvar j = 0; j < NST; j++) begin : g_step
		logic [RW-1:0] rs;
		logic          ge;

		// shift in one bit (not on the integer step) and try the subtract
		always_comb begin
			rs = (j == 0) ? rem_q[j] : {rem_q[j][RW-2:0], 1'b0};
			ge = rs >= {1'b0, den_q[j]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j+1] <= 1'b0;
			end else begin
				vld_q[j+1] <= vld_q[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_q[j+1]  <= ge ? (rs - {1'b0, den_q[j]}) : rs;
			quo_q[j+1]  <= {quo_q[j][FRAC_BITS-1:0], ge};
			den_q[j+1]  <= den_q[j];
			side_q[j+1] <= side_q[j];
		end
	end

	assign out_valid = vld_q[NST];
	assign quot      = quo_q[NST];
	assign side_out  = side_q[NST];
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for segment_plane_intersection: directed table, then random segments.
// Depends on spi_pkg and the segment_plane_intersection RTL; predicts each beat internally.
module tb_top;
	localparam int XW = spi_pkg::XW;
	localparam int WW = spi_pkg::WW;
	localparam int FB = spi_pkg::FRAC_BITS_DEF;
	localparam logic signed [WW-1:0] S64_MAX = spi_pkg::S64_MAX;
	localparam logic signed [WW-1:0] S64_MIN = spi_pkg::S64_MIN;

	typedef struct packed {
		logic signed [XW-1:0] nx, ny, nz, d;
		logic signed [XW-1:0] ax, ay, az;
		logic signed [XW-1:0] bx, by, bz;
	} query_t;

	typedef struct packed {
		logic                 hit;
		logic signed [XW-1:0] x, y, z;
	} cross_t;

	typedef struct packed {
		query_t q;
		logic   known;
		cross_t want;
	} row_t;

	localparam int  RAND_ITEMS = 830;
	localparam int  CYCLE_LIMIT = 200000;
	localparam int  DRAIN_CYCLES = FB + 12;
	localparam logic signed [XW-1:0] ONE = 1 <<< FB;
	localparam logic signed [XW-1:0] MAXV = 32'sh7fffffff;
	localparam logic signed [XW-1:0] MINV = 32'sh80000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, hit;
	logic signed [XW-1:0] cross_x, cross_y, cross_z;
	query_t drv = '0;
	logic   drv_known = 1'b0;
	cross_t drv_want = '0;

	cross_t pending_crossings[$];
	int     errors = 0;
	int     cycles = 0;

	segment_plane_intersection dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.normal_x(drv.nx), .normal_y(drv.ny), .normal_z(drv.nz), .plane_offset(drv.d),
		.start_x(drv.ax), .start_y(drv.ay), .start_z(drv.az),
		.end_x(drv.bx), .end_y(drv.by), .end_z(drv.bz),
		.done(done), .hit(hit), .cross_x(cross_x), .cross_y(cross_y), .cross_z(cross_z)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic signed [WW-1:0] sat_sum(input logic signed [WW-1:0] a,
			input logic signed [WW-1:0] b);
		logic signed [WW:0] s;
		s = $signed({a[WW-1], a}) + $signed({b[WW-1], b});
		if (s > $signed({1'b0, S64_MAX}))
			return S64_MAX;
		if (s < $signed({1'b1, S64_MIN}))
			return S64_MIN;
		return s[WW-1:0];
	endfunction

	function automatic logic signed [XW-1:0] clamp32(input logic signed [WW:0] v);
		if (v > 65'sd2147483647)
			return MAXV;
		if (v < -65'sd2147483648)
			return MINV;
		return v[XW-1:0];
	endfunction

	// Compute the crossing point of one query, or a zeroed miss
	function automatic cross_t predict_crossing(input query_t q);
		logic signed [XW-1:0]  n[3], p[3], e[3], r[3];
		logic signed [WW-1:0]  np, nr, num, den, prod, pterm;
		logic [WW-1:0]         un, ud;
		logic [127:0]          tq;
		logic signed [WW:0]    c;
		logic signed [XW-1:0]  outc[3];
		cross_t                res;
		n = '{q.nx, q.ny, q.nz};
		p = '{q.ax, q.ay, q.az};
		e = '{q.bx, q.by, q.bz};
		for (int i = 0; i < 3; i++)
			r[i] = clamp32((WW+1)'(e[i]) - (WW+1)'(p[i]));
		np = WW'(n[0]) * WW'(p[0]);
		nr = WW'(n[0]) * WW'(r[0]);
		for (int i = 1; i < 3; i++) begin
			np = sat_sum(np, WW'(n[i]) * WW'(p[i]));
			nr = sat_sum(nr, WW'(n[i]) * WW'(r[i]));
		end
		pterm = -(WW'(q.d) <<< FB);
		num = sat_sum(pterm, (np == S64_MIN) ? S64_MAX : -np);
		den = nr;
		res = '0;
		if (den == 0)
			return res;
		if (num != 0 && (num[WW-1] != den[WW-1]))
			return res;
		un = num[WW-1] ? -num : num;
		ud = den[WW-1] ? -den : den;
		if (un > ud)
			return res;
		tq = ({64'd0, un} << FB) / {64'd0, ud};
		for (int i = 0; i < 3; i++) begin
			prod = WW'(r[i]) * $signed(WW'(tq[FB:0]));
			c = (WW+1)'(p[i]) + (WW+1)'(prod >>> FB);
			outc[i] = clamp32(c);
		end
		res.hit = 1'b1;
		res.x = outc[0];
		res.y = outc[1];
		res.z = outc[2];
		return res;
	endfunction

	function automatic row_t mk(input logic signed [XW-1:0] nx, ny, nz, d, ax, ay, az, bx, by,
			bz, input logic known, input cross_t want);
		row_t rw;
		rw.q = '{nx, ny, nz, d, ax, ay, az, bx, by, bz};
		rw.known = known;
		rw.want = want;
		return rw;
	endfunction

	// Build a segment that mostly straddles its plane, with random content
	function automatic query_t crossing_query();
		query_t q;
		logic signed [WW-1:0] np, nr, tgt;
		int f;
		q.nx = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
		q.ny = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
		q.nz = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
		q.ax = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
		q.ay = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
		q.az = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
		q.bx = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
		q.by = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
		q.bz = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
		np = WW'(q.nx) * WW'(q.ax) + WW'(q.ny) * WW'(q.ay) + WW'(q.nz) * WW'(q.az);
		nr = WW'(q.nx) * WW'(q.bx - q.ax) + WW'(q.ny) * WW'(q.by - q.ay)
			+ WW'(q.nz) * WW'(q.bz - q.az);
		f = $urandom_range(0, 1100) - 50;
		tgt = np + (nr * f) / 1000;
		q.d = XW'(-(tgt >>> FB));
		return q;
	endfunction

	function automatic query_t noise_query();
		query_t q;
		q = {$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom};
		return q;
	endfunction

	// Record each accepted beat, check each done strobe against the oldest expectation
	always @(posedge clk) begin
		cross_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_crossings.size() == 0) begin
					$error("unexpected result beat");
					errors++;
				end else begin
					want = pending_crossings.pop_front();
					if (hit !== want.hit) begin
						$error("hit: expected %0d actual %0d", want.hit, hit);
						errors++;
					end
					if (cross_x !== want.x) begin
						$error("cross_x: expected %0d actual %0d", want.x, cross_x);
						errors++;
					end
					if (cross_y !== want.y) begin
						$error("cross_y: expected %0d actual %0d", want.y, cross_y);
						errors++;
					end
					if (cross_z !== want.z) begin
						$error("cross_z: expected %0d actual %0d", want.z, cross_z);
						errors++;
					end
				end
			end
			if (start && !busy)
				pending_crossings.push_back(drv_known ? drv_want : predict_crossing(drv));
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("segment_plane_intersection verification failed");
			$finish;
		end
	end

	// Present one beat and hold it until taken
	task automatic send_query(input query_t q, input logic known, input cross_t want,
			input bit may_idle);
		while (may_idle && $urandom_range(0, 99) < 37) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		drv = q;
		drv_known = known;
		drv_want = want;
		start = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	initial begin
		row_t   rows[$];
		cross_t miss;
		query_t q;
		int     waited;
		miss = '0;
		// Misses: degenerate normal, zero-length ray, all zero
		rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, miss));
		rows.push_back(mk(0, 0, 0, MAXV, 5, 6, 7, MAXV, MINV, 9, 1, miss));
		rows.push_back(mk(ONE, ONE, ONE, 3, 11, 12, 13, 11, 12, 13, 1, miss));
		// Start on the plane: hit at p1
		rows.push_back(mk(ONE, 0, 0, 0, 0, 5, 7, ONE, 9, 9, 1, '{1'b1, 0, 5, 7}));
		// Plane x = 1 reached at the far end
		rows.push_back(mk(ONE, 0, 0, -ONE, 0, 0, 0, ONE, 2 * ONE, 3 * ONE, 1,
			'{1'b1, ONE, 2 * ONE, 3 * ONE}));
		// Plane behind the start, and beyond the end
		rows.push_back(mk(ONE, 0, 0, -ONE, 0, 0, 0, -ONE, ONE, ONE, 1, miss));
		rows.push_back(mk(ONE, 0, 0, -ONE, 0, 0, 0, ONE / 2, ONE, ONE, 1, miss));
		// Halfway crossing, ray saturation and field extremes
		rows.push_back(mk(0, ONE, 0, 0, 0, -ONE, 0, 4 * ONE, ONE, -ONE, 0, miss));
		rows.push_back(mk(ONE, 0, 0, 0, MINV, 0, 0, MAXV, MAXV, MINV, 0, miss));
		rows.push_back(mk(MAXV, MAXV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MAXV, MAXV, 0, miss));
		rows.push_back(mk(MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MINV, MINV, 0, miss));
		rows.push_back(mk(MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, 0, miss));
		rows.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 0, miss));
		rows.push_back(mk(1, 1, 1, MINV, -1, 0, 1, MAXV, MAXV, MAXV, 0, miss));
		rows.push_back(mk(0, 0, ONE, -ONE, MAXV, MINV, 0, MINV, MAXV, 2 * ONE, 0, miss));

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i])
			send_query(rows[i].q, rows[i].known, rows[i].want, 0);

		for (int k = 0; k < RAND_ITEMS; k++) begin
			// Hold off until every expected result is in
			if (k == 200) begin
				@(negedge clk);
				start = 1'b0;
				while (pending_crossings.size() != 0)
					@(negedge clk);
			end
			case ($urandom_range(0, 9))
				0, 1: q = noise_query();
				default: q = crossing_query();
			endcase
			send_query(q, 0, miss, !(k >= 400 && k < 550));
		end
		@(negedge clk);
		start = 1'b0;

		waited = 0;
		while (pending_crossings.size() != 0) begin
			@(posedge clk);
			waited++;
			if (waited > 10 * DRAIN_CYCLES) begin
				$display("segment_plane_intersection verification failed");
				$finish;
			end
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("segment_plane_intersection verification clean");
		else
			$display("segment_plane_intersection verification failed");
		$finish;
	end

endmodule
